// ===== rtl/core/stbs_pkg.sv =====
// ============================================================================
// stbs_pkg
// Shared types, field widths and the control store of the sorted-table search.
// ============================================================================
package stbs_pkg;

    localparam int unsigned DEFAULT_TABLE_DEPTH = 1024;
    localparam int unsigned COUNT_W             = 11;
    localparam int unsigned LOAD_INDEX_W        = 10;
    localparam int unsigned VALUE_W             = 32;
    localparam int unsigned POSITION_W          = 10;
    localparam int unsigned IN_TDATA_W          = 80;
    localparam int unsigned OUT_TDATA_W         = 16;

    localparam logic OP_LOAD   = 1'b0;
    localparam logic OP_SEARCH = 1'b1;

    typedef logic [1:0] t_step;

    localparam t_step STEP_FETCH   = 2'd0;
    localparam t_step STEP_PROBE   = 2'd1;
    localparam t_step STEP_COMPARE = 2'd2;
    localparam t_step STEP_EMIT    = 2'd3;

    typedef enum logic [1:0] {
        COND_START,
        COND_EMPTY,
        COND_HIT,
        COND_SLOT_FREE
    } t_cond;

    typedef struct packed {
        logic  accept;
        logic  probe;
        logic  compare;
        logic  emit;
        t_cond cond;
        t_step jump_true;
        t_step jump_false;
    } t_ctrl;

    typedef struct packed {
        logic start;
        logic empty;
        logic hit;
        logic slot_free;
    } t_status;

    function automatic t_ctrl ucode(input t_step step);
        t_ctrl w;
        w = '0;
        case (step)
            STEP_FETCH: begin
                w.accept     = 1'b1;
                w.cond       = COND_START;
                w.jump_true  = STEP_PROBE;
                w.jump_false = STEP_FETCH;
            end
            STEP_PROBE: begin
                w.probe      = 1'b1;
                w.cond       = COND_EMPTY;
                w.jump_true  = STEP_EMIT;
                w.jump_false = STEP_COMPARE;
            end
            STEP_COMPARE: begin
                w.compare    = 1'b1;
                w.cond       = COND_HIT;
                w.jump_true  = STEP_EMIT;
                w.jump_false = STEP_PROBE;
            end
            STEP_EMIT: begin
                w.emit       = 1'b1;
                w.cond       = COND_SLOT_FREE;
                w.jump_true  = STEP_FETCH;
                w.jump_false = STEP_EMIT;
            end
            default: begin
                w.cond       = COND_START;
                w.jump_true  = STEP_FETCH;
                w.jump_false = STEP_FETCH;
            end
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/sorted_table_binary_search_core.sv =====
// ============================================================================
// sorted_table_binary_search_core
// Binary search over a table of signed 32-bit values held in ascending order.
// ============================================================================
// A load word writes one table entry, and the core stays ready for the next
// word. A search word runs a half-open-interval binary search over the first
// entry_count entries, capped at the table depth, and returns one word. The
// FETCH step accepts it; each probe then has a PROBE step that issues the
// synchronous table read and a COMPARE step that compares and narrows, and an
// EMIT step posts the result. A miss ends in a PROBE step that finds the
// interval empty. The single table read port serializes the probes. A finished
// result waits in an output register, so the next word can be accepted while it is pending.
module sorted_table_binary_search_core #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [stbs_pkg::COUNT_W-1:0]        i_cfg_wdata,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // load_index [9:0], entry_value [41:10], search_key [73:42], zero [79:74]
    input  logic [stbs_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
    // op [0]
    input  logic                                s_axis_tuser,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // position [9:0], zero [15:10]
    output logic [stbs_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
    // found [0]
    output logic                                m_axis_tuser
);

    localparam int unsigned AW = $clog2(TABLE_DEPTH);
    localparam int unsigned IW = (AW > stbs_pkg::LOAD_INDEX_W) ? AW + 1
                                                               : stbs_pkg::LOAD_INDEX_W + 1;

    logic [stbs_pkg::COUNT_W-1:0]        r_entry_count;
    logic                                r_out_valid;
    logic                                r_out_found;
    logic [stbs_pkg::POSITION_W-1:0]     r_out_position;

    stbs_pkg::t_ctrl                     ctrl;
    stbs_pkg::t_status                   status;

    logic [stbs_pkg::LOAD_INDEX_W-1:0]   load_index;
    logic signed [stbs_pkg::VALUE_W-1:0] entry_value;
    logic signed [stbs_pkg::VALUE_W-1:0] search_key;
    logic [IW-1:0]                       index_ext;
    logic                                accepted;
    logic                                load_we;
    logic [AW-1:0]                       raddr;
    logic signed [stbs_pkg::VALUE_W-1:0] rdata;
    logic                                empty;
    logic                                hit;
    logic                                found;
    logic [stbs_pkg::POSITION_W-1:0]     position;
    logic                                slot_free;

    assign load_index  = s_axis_tdata[stbs_pkg::LOAD_INDEX_W-1:0];
    assign entry_value = s_axis_tdata[stbs_pkg::LOAD_INDEX_W +: stbs_pkg::VALUE_W];
    assign search_key  = s_axis_tdata[stbs_pkg::LOAD_INDEX_W + stbs_pkg::VALUE_W
                                      +: stbs_pkg::VALUE_W];
    assign index_ext   = IW'(load_index);

    assign s_axis_tready = ctrl.accept;
    assign accepted      = s_axis_tvalid && ctrl.accept;
    assign load_we       = accepted && (s_axis_tuser == stbs_pkg::OP_LOAD)
                           && (index_ext < IW'(TABLE_DEPTH));
    assign slot_free     = !r_out_valid || m_axis_tready;

    always_comb begin
        status.start     = accepted && (s_axis_tuser == stbs_pkg::OP_SEARCH);
        status.empty     = empty;
        status.hit       = hit;
        status.slot_free = slot_free;
    end

    stbs_sequencer u_sequencer (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_status (status),
        .o_ctrl   (ctrl)
    );

    stbs_ram #(
        .WIDTH (stbs_pkg::VALUE_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (index_ext[AW-1:0]),
        .i_wdata (entry_value),
        .i_re    (ctrl.probe),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_datapath (
        .i_clk         (i_clk),
        .i_ctrl        (ctrl),
        .i_start       (status.start),
        .i_entry_count (r_entry_count),
        .i_key         (search_key),
        .i_rdata       (rdata),
        .o_raddr       (raddr),
        .o_empty       (empty),
        .o_hit         (hit),
        .o_found       (found),
        .o_position    (position)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_entry_count <= i_cfg_wdata;
            end
            if (ctrl.emit && slot_free) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
        if (ctrl.emit && slot_free) begin
            r_out_found    <= found;
            r_out_position <= position;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out_found;
    assign m_axis_tdata  = stbs_pkg::OUT_TDATA_W'(r_out_position);

endmodule

// ===== rtl/core/stbs_ram.sv =====
// ============================================================================
// stbs_ram
// Generic simple dual-port RAM with one write port and a registered read port.
// ============================================================================
module stbs_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 1024,
    localparam int unsigned AW   = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/core/stbs_sequencer.sv =====
// ============================================================================
// stbs_sequencer
// Step counter over the control store, with a two-way conditional jump.
// ============================================================================
module stbs_sequencer (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  stbs_pkg::t_status i_status,
    output stbs_pkg::t_ctrl  o_ctrl
);

    stbs_pkg::t_step r_step;
    stbs_pkg::t_step n_step;
    stbs_pkg::t_ctrl ctrl;
    logic            cond_true;

    always_comb begin
        ctrl = stbs_pkg::ucode(r_step);
        case (ctrl.cond)
            stbs_pkg::COND_START:     cond_true = i_status.start;
            stbs_pkg::COND_EMPTY:     cond_true = i_status.empty;
            stbs_pkg::COND_HIT:       cond_true = i_status.hit;
            stbs_pkg::COND_SLOT_FREE: cond_true = i_status.slot_free;
            default:                  cond_true = 1'b0;
        endcase
        n_step = cond_true ? ctrl.jump_true : ctrl.jump_false;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= stbs_pkg::STEP_FETCH;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl = ctrl;

endmodule

// ===== rtl/core/stbs_datapath.sv =====
// ============================================================================
// stbs_datapath
// Interval bounds, midpoint, key compare and search result registers.
// ============================================================================
module stbs_datapath #(
    parameter int unsigned TABLE_DEPTH = stbs_pkg::DEFAULT_TABLE_DEPTH,
    localparam int unsigned AW = $clog2(TABLE_DEPTH),
    localparam int unsigned NW = AW + 1
) (
    input  logic                                 i_clk,
    input  stbs_pkg::t_ctrl                      i_ctrl,
    input  logic                                 i_start,
    input  logic [stbs_pkg::COUNT_W-1:0]         i_entry_count,
    input  logic signed [stbs_pkg::VALUE_W-1:0]  i_key,
    input  logic signed [stbs_pkg::VALUE_W-1:0]  i_rdata,
    output logic [AW-1:0]                        o_raddr,
    output logic                                 o_empty,
    output logic                                 o_hit,
    output logic                                 o_found,
    output logic [stbs_pkg::POSITION_W-1:0]      o_position
);

    localparam int unsigned XW = (NW > stbs_pkg::COUNT_W) ? NW : stbs_pkg::COUNT_W;

    logic [NW-1:0]                       r_lo;
    logic [NW-1:0]                       r_hi;
    logic [AW-1:0]                       r_mid;
    logic signed [stbs_pkg::VALUE_W-1:0] r_key;
    logic                                r_found;
    logic [stbs_pkg::POSITION_W-1:0]     r_position;

    logic [XW-1:0] count_ext;
    logic [NW-1:0] count_sat;
    logic [NW-1:0] span;
    logic [NW-1:0] mid_full;
    logic [AW-1:0] mid;
    logic          less;

    always_comb begin
        count_ext = XW'(i_entry_count);
        count_sat = (count_ext > XW'(TABLE_DEPTH)) ? NW'(TABLE_DEPTH) : NW'(count_ext);
        span      = r_hi - r_lo - NW'(1);
        mid_full  = r_lo + (span >> 1);
        mid       = mid_full[AW-1:0];
        less      = i_rdata < r_key;
    end

    assign o_raddr = mid;
    assign o_empty = r_lo >= r_hi;
    assign o_hit   = i_rdata == r_key;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_lo       <= '0;
            r_hi       <= count_sat;
            r_key      <= i_key;
            r_found    <= 1'b0;
            r_position <= '0;
        end
        if (i_ctrl.probe) begin
            r_mid <= mid;
        end
        if (i_ctrl.compare) begin
            if (o_hit) begin
                r_found    <= 1'b1;
                r_position <= stbs_pkg::POSITION_W'(r_mid);
            end else if (less) begin
                r_lo <= NW'(r_mid) + NW'(1);
            end else begin
                r_hi <= NW'(r_mid);
            end
        end
    end

    assign o_found    = r_found;
    assign o_position = r_position;

endmodule

// ===== dv/sorted_table_binary_search_core_test.sv =====
// ============================================================================
// sorted_table_binary_search_core_test
// Self-checking testbench for the sorted-table binary search core.
// ============================================================================
// Loads ascending tables of random content, sets the searched entry count,
// and searches for present, neighboring, extreme and random keys. A scoreboard
// keeps its own copy of the table and predicts every result word. Both stream
// sides idle and stall at random.
module sorted_table_binary_search_core_test;

    localparam int unsigned TABLE_DEPTH  = stbs_pkg::DEFAULT_TABLE_DEPTH;
    localparam int unsigned COUNT_W      = stbs_pkg::COUNT_W;
    localparam int unsigned LOAD_INDEX_W = stbs_pkg::LOAD_INDEX_W;
    localparam int unsigned VALUE_W      = stbs_pkg::VALUE_W;
    localparam int unsigned POSITION_W   = stbs_pkg::POSITION_W;
    localparam int unsigned IN_TDATA_W   = stbs_pkg::IN_TDATA_W;
    localparam int unsigned OUT_TDATA_W  = stbs_pkg::OUT_TDATA_W;
    localparam logic signed [VALUE_W-1:0] VALUE_MIN = 32'sh8000_0000;
    localparam logic signed [VALUE_W-1:0] VALUE_MAX = 32'sh7FFF_FFFF;
    localparam int DRAIN_CYCLES = 40;
    localparam int unsigned TREE_STEP = 4_000_000;

    typedef struct packed {
        logic                  found;
        logic [POSITION_W-1:0] position;
    } t_lookup;

    class search_scoreboard;
        logic signed [VALUE_W-1:0] table_mem [TABLE_DEPTH];
        bit                        written [TABLE_DEPTH];
        logic [COUNT_W-1:0]        active_entries = '0;
        t_lookup                   answers [$];
        int errors = 0;
        int loads = 0;
        int searches = 0;
        int hits = 0;
        int misses = 0;
        int settings = 0;

        function void set_count(input logic [COUNT_W-1:0] value);
            active_entries = value;
            settings++;
        endfunction

        function t_lookup look_up(input logic signed [VALUE_W-1:0] key);
            int unsigned left;
            int unsigned right;
            int unsigned probe;
            t_lookup     r;
            r = '0;
            left = 0;
            right = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : active_entries;
            while (left < right && !r.found) begin
                probe = left + ((right - 1 - left) >> 1);
                if (table_mem[probe] < key) begin
                    left = probe + 1;
                end else if (table_mem[probe] > key) begin
                    right = probe;
                end else begin
                    r.found = 1'b1;
                    r.position = probe[POSITION_W-1:0];
                end
            end
            return r;
        endfunction

        // True when every probe of the search for this key lands on a loaded entry.
        function bit path_ok(input logic signed [VALUE_W-1:0] key);
            int unsigned left;
            int unsigned right;
            int unsigned probe;
            bit          ok;
            bit          done;
            ok = 1'b1;
            done = 1'b0;
            left = 0;
            right = (active_entries > TABLE_DEPTH) ? TABLE_DEPTH : active_entries;
            while (left < right && !done && ok) begin
                probe = left + ((right - 1 - left) >> 1);
                if (!written[probe]) begin
                    ok = 1'b0;
                end else if (table_mem[probe] < key) begin
                    left = probe + 1;
                end else if (table_mem[probe] > key) begin
                    right = probe;
                end else begin
                    done = 1'b1;
                end
            end
            return ok;
        endfunction

        function void note_word(input logic op, input logic [LOAD_INDEX_W-1:0] index,
                                input logic signed [VALUE_W-1:0] value,
                                input logic signed [VALUE_W-1:0] key);
            if (op == stbs_pkg::OP_LOAD) begin
                table_mem[index] = value;
                written[index] = 1'b1;
                loads++;
            end else begin
                answers.push_back(look_up(key));
                searches++;
            end
        endfunction

        function void check_word(input logic found, input logic [POSITION_W-1:0] position);
            t_lookup want;
            if (answers.size() == 0) begin
                errors++;
                $display("%0t: unexpected result word found=%0b position=%0d",
                         $time, found, position);
                return;
            end
            want = answers.pop_front();
            if (want.found) hits++; else misses++;
            if (want.found !== found || want.position !== position) begin
                errors++;
                $display("%0t: mismatch expected found=%0b position=%0d, got found=%0b position=%0d",
                         $time, want.found, want.position, found, position);
            end
        endfunction
    endclass

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_we;
    logic [COUNT_W-1:0]     i_cfg_wdata;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   s_axis_tuser;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    search_scoreboard sb;
    bit               calm;

    sorted_table_binary_search_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tuser (s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tuser (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #40_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic int pick_gap();
        int r;
        if (calm) return 0;
        r = $urandom_range(0, 99);
        if (r < 40) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 60);
    endfunction

    initial begin
        int gap;
        m_axis_tready = 1'b0;
        forever begin
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
            gap = pick_gap();
            if (gap > 0) begin
                m_axis_tready <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            sb.check_word(m_axis_tuser, m_axis_tdata[POSITION_W-1:0]);
        end
    end

    task automatic drive_word(input logic op, input logic [LOAD_INDEX_W-1:0] index,
                              input logic signed [VALUE_W-1:0] value,
                              input logic signed [VALUE_W-1:0] key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= {6'b0, key, value, index};
        do @(posedge i_clk); while (!s_axis_tready);
        sb.note_word(op, index, value, key);
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (sb.answers.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_count(input logic [COUNT_W-1:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_count(value);
        i_cfg_we    <= 1'b0;
    endtask

    // Each index owns its own band of values, so entries written in any
    // order still ascend across the whole table.
    function automatic longint tree_value(input int unsigned index);
        return longint'(VALUE_MIN) + longint'(index) * longint'(TREE_STEP)
               + longint'($urandom_range(0, TREE_STEP - 1));
    endfunction

    // Loads the upper levels of the full-depth search tree.
    task automatic fill_tree(input int unsigned levels);
        int unsigned lo_q  [$];
        int unsigned hi_q  [$];
        int unsigned lvl_q [$];
        int unsigned lo;
        int unsigned hi;
        int unsigned lvl;
        int unsigned mid;
        longint      v;
        lo_q.push_back(0);
        hi_q.push_back(TABLE_DEPTH);
        lvl_q.push_back(1);
        while (lo_q.size() != 0) begin
            lo  = lo_q.pop_front();
            hi  = hi_q.pop_front();
            lvl = lvl_q.pop_front();
            if (lo < hi && lvl <= levels) begin
                mid = lo + ((hi - 1 - lo) >> 1);
                v = tree_value(mid);
                drive_word(stbs_pkg::OP_LOAD, mid[LOAD_INDEX_W-1:0], v[VALUE_W-1:0], $urandom);
                lo_q.push_back(lo);
                hi_q.push_back(mid);
                lvl_q.push_back(lvl + 1);
                lo_q.push_back(mid + 1);
                hi_q.push_back(hi);
                lvl_q.push_back(lvl + 1);
            end
        end
    endtask

    // Loads every entry that a full-depth search for this key would probe.
    task automatic cover_path(input logic signed [VALUE_W-1:0] key);
        int unsigned lo;
        int unsigned hi;
        int unsigned mid;
        longint      v;
        bit          done;
        lo = 0;
        hi = TABLE_DEPTH;
        done = 1'b0;
        while (lo < hi && !done) begin
            mid = lo + ((hi - 1 - lo) >> 1);
            if (!sb.written[mid]) begin
                v = tree_value(mid);
                drive_word(stbs_pkg::OP_LOAD, mid[LOAD_INDEX_W-1:0], v[VALUE_W-1:0], $urandom);
            end
            if (sb.table_mem[mid] < key) begin
                lo = mid + 1;
            end else if (sb.table_mem[mid] > key) begin
                hi = mid;
            end else begin
                done = 1'b1;
            end
        end
    endtask

    // Ascending content with duplicates, tight or wide spacing, and sometimes
    // the most negative and most positive values at the ends.
    task automatic fill_ascending(input int entries);
        longint cur;
        longint step_max;
        int     i;
        case ($urandom_range(0, 2))
            0:       step_max = 3;
            1:       step_max = 1000;
            default: step_max = 64'd4294967296 / (entries + 1);
        endcase
        cur = longint'(VALUE_MIN)
              + longint'($urandom_range(0, 32'(64'hFFFF_FFFF - step_max * longint'(entries))));
        if (step_max < 4) cur = longint'(signed'($urandom));
        if ($urandom_range(0, 7) == 0) cur = longint'(VALUE_MIN);
        for (i = 0; i < entries; i++) begin
            if (i > 0 && $urandom_range(0, 7) != 0) begin
                cur += longint'($urandom_range(0, 32'(step_max)));
            end
            if (cur > longint'(VALUE_MAX)) cur = longint'(VALUE_MAX);
            if (i == entries - 1 && $urandom_range(0, 7) == 0) cur = longint'(VALUE_MAX);
            drive_word(stbs_pkg::OP_LOAD, i[LOAD_INDEX_W-1:0], cur[VALUE_W-1:0], $urandom);
        end
    endtask

    task automatic run_phase(input logic [COUNT_W-1:0] count, input bit reload,
                             input int queries);
        int                        entries;
        int                        r;
        int                        idx;
        logic signed [VALUE_W-1:0] key;
        settle();
        calm = ($urandom_range(0, 3) == 0);
        write_count(count);
        entries = (count > TABLE_DEPTH) ? int'(TABLE_DEPTH) : int'(count);
        if (reload) fill_ascending(entries);
        repeat (queries) begin
            if ($urandom_range(0, 9) == 0) begin
                drive_word(stbs_pkg::OP_LOAD, LOAD_INDEX_W'($urandom), $urandom, $urandom);
            end
            r = $urandom_range(0, 99);
            if (entries == 0 || r >= 80) begin
                key = $urandom;
            end else begin
                idx = $urandom_range(0, entries - 1);
                if (!sb.written[idx]) idx = (entries - 1) >> 1;
                key = sb.table_mem[idx];
                if (r >= 70) key = $urandom_range(0, 1) ? VALUE_MIN : VALUE_MAX;
                else if (r >= 55) key = $urandom_range(0, 1) ? key + 1 : key - 1;
            end
            if (entries != 0 && !sb.path_ok(key)) begin
                key = sb.table_mem[(entries - 1) >> 1];
            end
            drive_word(stbs_pkg::OP_SEARCH, LOAD_INDEX_W'($urandom), $urandom, key);
        end
    endtask

    initial begin
        int                 base_total;
        int                 r;
        logic [COUNT_W-1:0] count;
        sb = new();
        calm          = 1'b0;
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_wdata   = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = stbs_pkg::OP_LOAD;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        settle();

        // Empty table.
        write_count(11'd0);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, 0);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, VALUE_MIN);
        drive_word(stbs_pkg::OP_LOAD, 10'd0, VALUE_MIN, '0);
        drive_word(stbs_pkg::OP_LOAD, 10'd1, -5, '0);
        drive_word(stbs_pkg::OP_LOAD, 10'd2, -5, '0);
        drive_word(stbs_pkg::OP_LOAD, 10'd3, 0, '0);
        drive_word(stbs_pkg::OP_LOAD, 10'd4, 7, '0);
        drive_word(stbs_pkg::OP_LOAD, 10'd5, 7, '0);
        drive_word(stbs_pkg::OP_LOAD, 10'd6, 100, '0);
        drive_word(stbs_pkg::OP_LOAD, 10'd7, VALUE_MAX, '0);
        settle();
        write_count(11'd1);
        drive_word(stbs_pkg::OP_SEARCH, '1, '1, VALUE_MIN);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, 0);
        settle();
        write_count(11'd8);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, VALUE_MIN);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, VALUE_MAX);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, -5);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, 7);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, 0);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, 100);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, 1);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, -6);
        // Break the ordering and follow the probe path.
        drive_word(stbs_pkg::OP_LOAD, 10'd3, VALUE_MAX, '0);
        drive_word(stbs_pkg::OP_LOAD, 10'd5, VALUE_MIN, '0);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, 100);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, 7);
        drive_word(stbs_pkg::OP_SEARCH, '0, '0, VALUE_MAX);

        // Full-depth table held sparsely: the upper tree levels plus a few
        // complete search paths, then counts beyond the depth.
        settle();
        fill_tree(5);
        cover_path(VALUE_MIN);
        cover_path(VALUE_MAX);
        repeat (3) cover_path($urandom);
        run_phase(COUNT_W'(TABLE_DEPTH), 1'b0, 24);
        run_phase(11'h7FF, 1'b0, 10);
        run_phase(COUNT_W'(TABLE_DEPTH + 1), 1'b0, 8);

        base_total = sb.loads + sb.searches;
        while (sb.loads + sb.searches < base_total + 520) begin
            r = $urandom_range(0, 99);
            if (r < 55)      count = COUNT_W'($urandom_range(1, 16));
            else if (r < 75) count = COUNT_W'($urandom_range(17, 100));
            else if (r < 85) count = COUNT_W'($urandom_range(101, 400));
            else if (r < 90) count = '0;
            else if (r < 95) count = COUNT_W'(TABLE_DEPTH);
            else             count = COUNT_W'($urandom_range(TABLE_DEPTH + 1, 11'h7FF));
            run_phase(count, count <= 400, $urandom_range(8, 30));
        end

        settle();
        $display("Ran %0d loads and %0d searches under %0d entry count settings.",
                 sb.loads, sb.searches, sb.settings);
        $display("Searches ended in %0d hits and %0d misses; %0d errors.",
                 sb.hits, sb.misses, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
